@@ src/rhc_pkg.sv @@
// Package for the RGB to HSV converter: widths, the hue sector code and the
// payload carried through the divider stages. No dependencies.
package rhc_pkg;

   localparam int COMPONENT_BITS = 12;
   localparam int HUE_BITS       = 16;
   localparam int DIV_STEPS      = (HUE_BITS > COMPONENT_BITS) ? HUE_BITS : COMPONENT_BITS;
   localparam int REM_BITS       = COMPONENT_BITS + 3;

   typedef enum logic [1:0] {
      SECTOR_RED,
      SECTOR_GREEN,
      SECTOR_BLUE
   } rhc_sector_type;

   typedef struct packed {
      logic [REM_BITS-1:0]       hue_rem;
      logic [REM_BITS-1:0]       hue_div;
      logic [DIV_STEPS-1:0]      hue_quo;
      logic [COMPONENT_BITS-1:0] sat_rem;
      logic [COMPONENT_BITS-1:0] sat_div;
      logic [DIV_STEPS-1:0]      sat_low;
      logic [DIV_STEPS-1:0]      sat_quo;
      logic [COMPONENT_BITS-1:0] value;
      logic                      grey;
      logic                      black;
   } rhc_div_type;

endpackage

@@ src/rhc_req_if.sv @@
// Pixel request channel of the RGB to HSV converter.
// Depends on rhc_pkg for the component width.
interface rhc_req_if;
   import rhc_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [COMPONENT_BITS-1:0] red;
   logic [COMPONENT_BITS-1:0] green;
   logic [COMPONENT_BITS-1:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink (input valid, input red, input green, input blue, output ready);

endinterface

@@ src/rhc_rsp_if.sv @@
// HSV response channel of the RGB to HSV converter.
// Depends on rhc_pkg for the hue and component widths.
interface rhc_rsp_if;
   import rhc_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [HUE_BITS-1:0]       hue_turn;
   logic [COMPONENT_BITS-1:0] saturation_frac;
   logic [COMPONENT_BITS-1:0] value_level;

   modport source (output valid, output hue_turn, output saturation_frac,
                   output value_level, input ready);
   modport sink (input valid, input hue_turn, input saturation_frac,
                 input value_level, output ready);

endinterface

@@ src/rgb_to_hsv_converter.sv @@
// RGB to HSV converter: one pixel word in, one HSV word out, no state.
// The pipeline has two stages for max, min, chroma and the division operands,
// then one stage per quotient bit.
// Throughput is one word per cycle; the whole pipeline holds while the output
// word waits. Synchronous active-high reset clears all valid bits.
// Depends on rhc_pkg, rhc_req_if, rhc_rsp_if and rhc_div_step.
module rgb_to_hsv_converter (
   input logic      clock,
   input logic      reset,
   rhc_req_if.sink  req,
   rhc_rsp_if.source rsp
);
   import rhc_pkg::*;

   logic                      advance;

   logic                      s1_valid_ff;
   logic [COMPONENT_BITS-1:0] s1_red_ff;
   logic [COMPONENT_BITS-1:0] s1_green_ff;
   logic [COMPONENT_BITS-1:0] s1_blue_ff;
   logic [COMPONENT_BITS-1:0] s1_value_ff;
   logic [COMPONENT_BITS-1:0] s1_chroma_ff;
   rhc_sector_type            s1_sector_ff;

   logic [COMPONENT_BITS-1:0] value_in;
   logic [COMPONENT_BITS-1:0] low_in;
   rhc_sector_type            sector_in;

   logic                      s2_valid_ff;
   rhc_div_type               s2_data_ff;
   rhc_div_type               s2_data_in;

   logic [REM_BITS-1:0]         chroma_ext;
   logic [REM_BITS-1:0]         red_ext;
   logic [REM_BITS-1:0]         green_ext;
   logic [REM_BITS-1:0]         blue_ext;
   logic [REM_BITS-1:0]         turn;
   logic [REM_BITS-1:0]         numer;
   logic [2*COMPONENT_BITS-1:0] sat_numer;

   logic                      step_valid [0:DIV_STEPS];
   rhc_div_type               step_data  [0:DIV_STEPS];
   rhc_div_type               last;

   assign advance   = !rsp.valid || rsp.ready;
   assign req.ready = advance;

   always_comb begin
      if (req.red >= req.green && req.red >= req.blue) begin
         sector_in = SECTOR_RED;
         value_in  = req.red;
      end else if (req.green >= req.blue) begin
         sector_in = SECTOR_GREEN;
         value_in  = req.green;
      end else begin
         sector_in = SECTOR_BLUE;
         value_in  = req.blue;
      end
      if (req.red <= req.green && req.red <= req.blue) begin
         low_in = req.red;
      end else if (req.green <= req.blue) begin
         low_in = req.green;
      end else begin
         low_in = req.blue;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_red_ff    <= req.red;
         s1_green_ff  <= req.green;
         s1_blue_ff   <= req.blue;
         s1_value_ff  <= value_in;
         s1_chroma_ff <= value_in - low_in;
         s1_sector_ff <= sector_in;
      end
   end

   // The hue numerator always lies in [0, 6*chroma), so modular arithmetic on
   // REM_BITS bits gives it exactly.
   always_comb begin
      chroma_ext = REM_BITS'(s1_chroma_ff);
      red_ext    = REM_BITS'(s1_red_ff);
      green_ext  = REM_BITS'(s1_green_ff);
      blue_ext   = REM_BITS'(s1_blue_ff);
      turn       = (chroma_ext << 2) + (chroma_ext << 1);
      unique case (s1_sector_ff)
         SECTOR_RED: begin
            if (s1_green_ff >= s1_blue_ff) begin
               numer = green_ext - blue_ext;
            end else begin
               numer = turn + green_ext - blue_ext;
            end
         end
         SECTOR_GREEN: numer = (chroma_ext << 1) + blue_ext - red_ext;
         SECTOR_BLUE:  numer = (chroma_ext << 2) + red_ext - green_ext;
         default:      numer = '0;
      endcase
      sat_numer = {s1_chroma_ff, {COMPONENT_BITS{1'b0}}}
                - (2*COMPONENT_BITS)'(s1_chroma_ff);

      s2_data_in.hue_rem = numer;
      s2_data_in.hue_div = turn;
      s2_data_in.hue_quo = '0;
      s2_data_in.sat_rem = sat_numer[2*COMPONENT_BITS-1:COMPONENT_BITS];
      s2_data_in.sat_div = s1_value_ff;
      s2_data_in.sat_low = DIV_STEPS'(sat_numer[COMPONENT_BITS-1:0])
                           << (DIV_STEPS - COMPONENT_BITS);
      s2_data_in.sat_quo = '0;
      s2_data_in.value   = s1_value_ff;
      s2_data_in.grey    = (s1_chroma_ff == '0);
      s2_data_in.black   = (s1_value_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_data_ff <= s2_data_in;
      end
   end

   assign step_valid[0] = s2_valid_ff;
   assign step_data[0]  = s2_data_ff;

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
      rhc_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (step_valid[i]),
         .in_data   (step_data[i]),
         .out_valid (step_valid[i+1]),
         .out_data  (step_data[i+1])
      );
   end

   assign last                = step_data[DIV_STEPS];
   assign rsp.valid           = step_valid[DIV_STEPS];
   assign rsp.hue_turn        = last.grey ? '0 : last.hue_quo[DIV_STEPS-1 -: HUE_BITS];
   assign rsp.saturation_frac = last.black ? '0
                                           : last.sat_quo[DIV_STEPS-1 -: COMPONENT_BITS];
   assign rsp.value_level     = last.value;

endmodule

@@ src/rhc_div_step.sv @@
// One registered restoring-division step for both the hue and the saturation
// quotients. Depends on rhc_pkg for the stage payload type.
module rhc_div_step (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_valid,
   input  rhc_pkg::rhc_div_type in_data,
   output logic                out_valid,
   output rhc_pkg::rhc_div_type out_data
);
   import rhc_pkg::*;

   logic                    valid_ff;
   rhc_div_type             data_ff;
   rhc_div_type             data_in;
   logic [REM_BITS:0]       hue_trial;
   logic [REM_BITS:0]       hue_diff;
   logic [COMPONENT_BITS:0] sat_trial;
   logic [COMPONENT_BITS:0] sat_diff;

   always_comb begin
      data_in   = in_data;
      hue_trial = {in_data.hue_rem, 1'b0};
      hue_diff  = hue_trial - {1'b0, in_data.hue_div};
      sat_trial = {in_data.sat_rem, in_data.sat_low[DIV_STEPS-1]};
      sat_diff  = sat_trial - {1'b0, in_data.sat_div};

      data_in.hue_quo = {in_data.hue_quo[DIV_STEPS-2:0], ~hue_diff[REM_BITS]};
      data_in.hue_rem = hue_diff[REM_BITS] ? hue_trial[REM_BITS-1:0] : hue_diff[REM_BITS-1:0];
      data_in.sat_quo = {in_data.sat_quo[DIV_STEPS-2:0], ~sat_diff[COMPONENT_BITS]};
      data_in.sat_rem = sat_diff[COMPONENT_BITS] ? sat_trial[COMPONENT_BITS-1:0]
                                                 : sat_diff[COMPONENT_BITS-1:0];
      data_in.sat_low = {in_data.sat_low[DIV_STEPS-2:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

@@ src/rhc_checker.sv @@
// Port-level checks for the RGB to HSV converter, attached by bind.
// Depends on rhc_pkg and on the top level's channel interfaces.
module rhc_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [rhc_pkg::HUE_BITS-1:0]       rsp_hue_turn,
   input logic [rhc_pkg::COMPONENT_BITS-1:0] rsp_saturation_frac,
   input logic [rhc_pkg::COMPONENT_BITS-1:0] rsp_value_level
);
   import rhc_pkg::*;

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Response word valid right after reset.");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hue_turn)
         && $stable(rsp_saturation_frac) && $stable(rsp_value_level))
      else $error("Stalled response word changed.");

   a_accept_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("Request refused while the output stage is empty.");

   a_black_pixel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_value_level == '0 |-> rsp_saturation_frac == '0 && rsp_hue_turn == '0)
      else $error("Black pixel with nonzero saturation or hue.");

   a_grey_hue: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturation_frac == '0 |-> rsp_hue_turn == '0)
      else $error("Unsaturated pixel with nonzero hue.");

endmodule

bind rgb_to_hsv_converter rhc_checker u_rhc_checker (
   .clock               (clock),
   .reset               (reset),
   .req_ready           (req.ready),
   .rsp_valid           (rsp.valid),
   .rsp_ready           (rsp.ready),
   .rsp_hue_turn        (rsp.hue_turn),
   .rsp_saturation_frac (rsp.saturation_frac),
   .rsp_value_level     (rsp.value_level)
);

@@ dv/rgb_to_hsv_converter_tb.sv @@
// Self-checking testbench for rgb_to_hsv_converter: directed and random RGB pixel words
// under varied handshake idling, checked against an in-bench fixed-point HSV predictor.
// Depends on rhc_pkg, rhc_req_if, rhc_rsp_if and the converter RTL.
module rgb_to_hsv_converter_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rhc_pkg::*;

   localparam int LATENCY      = DIV_STEPS + 2;
   localparam int STALL_LIMIT  = 5000;
   localparam logic [COMPONENT_BITS-1:0] FULL_CODE = '1;
   localparam int GREEN_OFFSET = 2;
   localparam int BLUE_OFFSET  = 4;
   localparam int SECTOR_COUNT = 6;

   typedef struct packed {
      logic [HUE_BITS-1:0]       hue;
      logic [COMPONENT_BITS-1:0] sat;
      logic [COMPONENT_BITS-1:0] value;
   } hsv_word_type;

   logic clock;
   logic reset;

   rhc_req_if req_bus ();
   rhc_rsp_if rsp_bus ();

   rgb_to_hsv_converter dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   hsv_word_type hsv_expected[$];
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int mismatches    = 0;
   int pixels_sent   = 0;
   int words_checked = 0;
   int grey_count    = 0;
   int black_count   = 0;
   int wrap_count    = 0;
   int quiet_cycles  = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic hsv_word_type convert_pixel(input logic [COMPONENT_BITS-1:0] r,
                                                  input logic [COMPONENT_BITS-1:0] g,
                                                  input logic [COMPONENT_BITS-1:0] b);
      longint unsigned rv, gv, bv, top, bottom, chroma, turn, num;
      rhc_sector_type  sector;
      hsv_word_type    hsv;
      rv = 64'(r);
      gv = 64'(g);
      bv = 64'(b);
      top = rv;
      if (gv > top) top = gv;
      if (bv > top) top = bv;
      bottom = rv;
      if (gv < bottom) bottom = gv;
      if (bv < bottom) bottom = bv;
      chroma = top - bottom;
      hsv.value = COMPONENT_BITS'(top);
      hsv.sat = (top == 0) ? '0 : COMPONENT_BITS'((chroma * 64'(FULL_CODE)) / top);
      hsv.hue = '0;
      if (chroma != 0) begin
         turn = SECTOR_COUNT * chroma;
         if (top == rv) sector = SECTOR_RED;
         else if (top == gv) sector = SECTOR_GREEN;
         else sector = SECTOR_BLUE;
         case (sector)
            SECTOR_RED: begin
               // A negative hue is wrapped forward by one full turn.
               num = (gv >= bv) ? gv - bv : turn - (bv - gv);
            end
            SECTOR_GREEN: begin
               num = GREEN_OFFSET * chroma + bv - rv;
            end
            default: begin
               num = BLUE_OFFSET * chroma + rv - gv;
            end
         endcase
         hsv.hue = HUE_BITS'((num << HUE_BITS) / turn);
      end
      return hsv;
   endfunction

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      mismatches++;
   endtask

   task automatic send_pixel(input logic [COMPONENT_BITS-1:0] r,
                             input logic [COMPONENT_BITS-1:0] g,
                             input logic [COMPONENT_BITS-1:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.red   <= r;
      req_bus.green <= g;
      req_bus.blue  <= b;
      do @(posedge clock); while (!req_bus.ready);
      hsv_expected.push_back(convert_pixel(r, g, b));
      pixels_sent++;
      if (r == g && g == b) grey_count++;
      if (r == 0 && g == 0 && b == 0) black_count++;
      if (r >= g && r >= b && b > g) wrap_count++;
   endtask

   task automatic wait_until_drained();
      while (hsv_expected.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed_pixels();
      send_pixel(0, 0, 0);
      send_pixel(FULL_CODE, FULL_CODE, FULL_CODE);
      send_pixel(2048, 2048, 2048);
      send_pixel(1, 1, 1);
      send_pixel(FULL_CODE, 0, 0);
      send_pixel(0, FULL_CODE, 0);
      send_pixel(0, 0, FULL_CODE);
      send_pixel(FULL_CODE, FULL_CODE, 0);
      send_pixel(0, FULL_CODE, FULL_CODE);
      send_pixel(FULL_CODE, 0, FULL_CODE);
      send_pixel(FULL_CODE, 0, 1);
      send_pixel(FULL_CODE, 1, FULL_CODE - 1'b1);
      send_pixel(1, 0, 1);
      send_pixel(1, 0, 0);
      send_pixel(0, 1, 0);
      send_pixel(0, 0, 1);
      send_pixel(FULL_CODE, FULL_CODE - 1'b1, FULL_CODE - 1'b1);
      send_pixel(FULL_CODE - 1'b1, FULL_CODE, FULL_CODE);
      send_pixel(12'hAAA, 12'h555, 12'hFFF);
      send_pixel(12'h555, 12'hAAA, 12'h000);
      send_pixel(FULL_CODE, 2048, 0);
   endtask

   task automatic test_random_pixels(input int count);
      int mode;
      int pick;
      logic [COMPONENT_BITS-1:0] r, g, b;
      repeat (count) begin
         mode = $urandom_range(9);
         r = COMPONENT_BITS'($urandom_range(FULL_CODE));
         g = COMPONENT_BITS'($urandom_range(FULL_CODE));
         b = COMPONENT_BITS'($urandom_range(FULL_CODE));
         case (mode)
            5: begin
               pick = $urandom_range(2);
               if (pick == 0) g = r;
               else if (pick == 1) b = g;
               else b = r;
            end
            6: begin
               g = r;
               b = r;
            end
            7: begin
               r = COMPONENT_BITS'($urandom_range(15));
               g = COMPONENT_BITS'($urandom_range(15));
               b = COMPONENT_BITS'($urandom_range(15));
            end
            8: begin
               r = FULL_CODE - COMPONENT_BITS'($urandom_range(15));
               g = FULL_CODE - COMPONENT_BITS'($urandom_range(15));
               b = FULL_CODE - COMPONENT_BITS'($urandom_range(15));
            end
            9: begin
               pick = $urandom_range(2);
               if (pick == 0) begin
                  r = FULL_CODE;
                  g = 0;
               end else if (pick == 1) begin
                  g = FULL_CODE;
                  b = 0;
               end else begin
                  b = FULL_CODE;
                  r = 0;
               end
            end
            default: ;
         endcase
         send_pixel(r, g, b);
      end
   endtask

   task automatic test_pause_until_drained();
      test_random_pixels(12);
      req_bus.valid <= 1'b0;
      wait_until_drained();
      test_random_pixels(12);
   endtask

   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      hsv_word_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         words_checked++;
         if (hsv_expected.size() == 0) begin
            report_mismatch($sformatf("unexpected word hue=%0d sat=%0d value=%0d",
                                      rsp_bus.hue_turn, rsp_bus.saturation_frac,
                                      rsp_bus.value_level));
         end else begin
            want = hsv_expected.pop_front();
            if (rsp_bus.hue_turn !== want.hue)
               report_mismatch($sformatf("hue_turn got %0d expected %0d",
                                         rsp_bus.hue_turn, want.hue));
            if (rsp_bus.saturation_frac !== want.sat)
               report_mismatch($sformatf("saturation_frac got %0d expected %0d",
                                         rsp_bus.saturation_frac, want.sat));
            if (rsp_bus.value_level !== want.value)
               report_mismatch($sformatf("value_level got %0d expected %0d",
                                         rsp_bus.value_level, want.value));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      while (quiet_cycles < STALL_LIMIT) @(posedge clock);
      $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
      $display("Verification failed");
      $finish;
   end

   initial begin
      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.red   <= '0;
      req_bus.green <= '0;
      req_bus.blue  <= '0;
      send_idle_pct = 27;
      recv_idle_pct = 51;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_directed_pixels();
      test_random_pixels(130);
      send_idle_pct = 51;
      recv_idle_pct = 27;
      test_random_pixels(110);
      test_pause_until_drained();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_pixels(130);
      req_bus.valid <= 1'b0;

      wait_until_drained();
      repeat (2 * LATENCY) @(posedge clock);
      if (hsv_expected.size() != 0)
         report_mismatch($sformatf("%0d words never arrived", hsv_expected.size()));

      $display("Converted %0d pixels and checked %0d HSV words, %0d field mismatches.",
               pixels_sent, words_checked, mismatches);
      $display("Covered %0d grey, %0d black and %0d wrapped-hue pixels.",
               grey_count, black_count, wrap_count);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
